### hw/rtl/rfifo_pkg.sv
// ----------------------------------------------------------------------------
// rfifo_pkg
// Shared widths, limits and operation codes for the ring fifo with bulk
// read, peek and remove.
// ----------------------------------------------------------------------------
package rfifo_pkg;

    // storage geometry
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int ELEM_W      = 32;

    // counts, occupancy and capacity share one width
    localparam int CNT_W       = 7;
    localparam int MAX_REQUEST = 64;
    localparam int BURST_SAT   = 127;

    localparam int OP_W        = 3;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ELEM_W-1:0] elem_t;

    // operation codes
    localparam op_t OP_WRITE  = OP_W'(0);
    localparam op_t OP_READ   = OP_W'(1);
    localparam op_t OP_PEEK   = OP_W'(2);
    localparam op_t OP_REMOVE = OP_W'(3);
    localparam op_t OP_CLEAR  = OP_W'(4);

    // one result transaction as held in the output register
    typedef struct packed {
        elem_t read_data;
        logic  data_valid;
        cnt_t  transfer_count;
        cnt_t  occupancy;
        cnt_t  free_space;
        logic  last;
    } result_t;

endpackage

### hw/rtl/ring_fifo_bulk_read_write.sv
// ----------------------------------------------------------------------------
// ring_fifo_bulk_read_write
// Circular fifo of 32-bit elements in a single-port-read, single-port-write
// memory, with burst writes, bulk read, peek, remove and clear.
// ----------------------------------------------------------------------------
// Timing: a transaction is taken in every cycle as long as the output
// register is free or being emptied, no read stream is in flight and no
// capacity write waits. A read or peek that returns n elements streams them
// one per cycle through the memory's registered read port while the output
// register keeps up; the next input transaction waits until the last of them
// has left the pending stage. The read port sets that rate. Writing the
// capacity register empties the fifo. There is no clearing pass after
// reset: slots are read only after they have been written.
// ----------------------------------------------------------------------------
module ring_fifo_bulk_read_write (
    input  logic                          aclk,
    input  logic                          aresetn,

    // capacity register write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfifo_pkg::CNT_W-1:0]   cfg_capacity,

    // input transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rfifo_pkg::OP_W-1:0]    s_operation,
    input  logic [rfifo_pkg::ELEM_W-1:0]  s_write_data,
    input  logic                          s_write_last,
    input  logic [rfifo_pkg::CNT_W-1:0]   s_request_count,

    // result transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rfifo_pkg::ELEM_W-1:0]  m_read_data,
    output logic                          m_data_valid,
    output logic [rfifo_pkg::CNT_W-1:0]   m_transfer_count,
    output logic [rfifo_pkg::CNT_W-1:0]   m_occupancy,
    output logic [rfifo_pkg::CNT_W-1:0]   m_free_space,
    output logic                          m_last
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // element storage
    rfifo_pkg::elem_t mem [rfifo_pkg::DEPTH];
    rfifo_pkg::elem_t mem_rdata_reg;

    // control and index state
    state_t            state_reg, state_next;
    rfifo_pkg::cnt_t   cap_reg, cap_next;
    rfifo_pkg::addr_t  rd_index_reg, rd_index_next;
    rfifo_pkg::addr_t  wr_index_reg, wr_index_next;
    rfifo_pkg::cnt_t   fill_reg, fill_next;
    rfifo_pkg::cnt_t   burst_reg, burst_next;

    // read streaming state
    rfifo_pkg::addr_t  rd_ptr_reg, rd_ptr_next;
    rfifo_pkg::cnt_t   remain_reg, remain_next;
    rfifo_pkg::cnt_t   xfer_reg, xfer_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_last_reg, pend_last_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    rfifo_pkg::result_t out_reg, out_next;

    // datapath helpers
    rfifo_pkg::cnt_t   cap_eff;
    rfifo_pkg::cnt_t   req_clip;
    rfifo_pkg::cnt_t   n_take;
    rfifo_pkg::cnt_t   rd_sum;
    rfifo_pkg::cnt_t   rd_wrap;
    rfifo_pkg::cnt_t   wr_inc;
    rfifo_pkg::cnt_t   ptr_inc;
    logic              out_free;
    logic              in_accept;
    logic              cfg_accept;
    logic              mem_we;
    logic              mem_re;
    logic              pend_move;

    // effective slot count: zero acts as one, above depth acts as depth
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = rfifo_pkg::CNT_W'(1);
        end else if (cap_reg > rfifo_pkg::CNT_W'(rfifo_pkg::DEPTH)) begin
            cap_eff = rfifo_pkg::CNT_W'(rfifo_pkg::DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    // element count of a read, peek or remove
    always_comb begin
        if (s_request_count > rfifo_pkg::CNT_W'(rfifo_pkg::MAX_REQUEST)) begin
            req_clip = rfifo_pkg::CNT_W'(rfifo_pkg::MAX_REQUEST);
        end else begin
            req_clip = s_request_count;
        end
        n_take = (req_clip < fill_reg) ? req_clip : fill_reg;
    end

    // read index after consuming n_take: sum stays below twice the capacity
    assign rd_sum  = {1'b0, rd_index_reg} + n_take;
    assign rd_wrap = (rd_sum >= cap_eff) ? (rd_sum - cap_eff) : rd_sum;

    // single-step index advances with wrap at the capacity
    assign wr_inc  = {1'b0, wr_index_reg} + rfifo_pkg::CNT_W'(1);
    assign ptr_inc = {1'b0, rd_ptr_reg} + rfifo_pkg::CNT_W'(1);

    // handshakes
    assign out_free   = !out_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && !pend_valid_reg && out_free && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign in_accept  = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    // streaming: pending element moves to the output register when it frees
    assign pend_move = pend_valid_reg && out_free;
    assign mem_re    = (state_reg == ST_READ) && (remain_reg != '0)
                       && (!pend_valid_reg || pend_move);

    // element append; reads never target a slot written in the same cycle
    assign mem_we = in_accept && (s_operation == rfifo_pkg::OP_WRITE) && (fill_reg < cap_eff);

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_index_reg] <= s_write_data;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[rd_ptr_reg];
        end
    end

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        rd_index_next   = rd_index_reg;
        wr_index_next   = wr_index_reg;
        fill_next       = fill_reg;
        burst_next      = burst_reg;
        rd_ptr_next     = rd_ptr_reg;
        remain_next     = remain_reg;
        xfer_next       = xfer_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;

        // capacity write empties the fifo
        if (cfg_accept) begin
            cap_next      = cfg_capacity;
            rd_index_next = '0;
            wr_index_next = '0;
            fill_next     = '0;
            burst_next    = '0;
        end

        // input transaction
        if (in_accept) begin
            out_next.read_data  = '0;
            out_next.data_valid = 1'b0;
            out_next.last       = 1'b1;
            case (s_operation)
                rfifo_pkg::OP_WRITE: begin
                    if (mem_we) begin
                        wr_index_next = (wr_inc >= cap_eff) ? '0
                                        : wr_inc[rfifo_pkg::ADDR_W-1:0];
                        fill_next     = fill_reg + rfifo_pkg::CNT_W'(1);
                        if (burst_reg < rfifo_pkg::CNT_W'(rfifo_pkg::BURST_SAT)) begin
                            burst_next = burst_reg + rfifo_pkg::CNT_W'(1);
                        end
                    end
                    if (s_write_last) begin
                        out_valid_next          = 1'b1;
                        out_next.transfer_count = burst_next;
                        burst_next              = '0;
                    end
                end
                rfifo_pkg::OP_READ, rfifo_pkg::OP_PEEK: begin
                    if (n_take == '0) begin
                        out_valid_next          = 1'b1;
                        out_next.transfer_count = '0;
                    end else begin
                        state_next  = ST_READ;
                        rd_ptr_next = rd_index_reg;
                        remain_next = n_take;
                        xfer_next   = n_take;
                        if (s_operation == rfifo_pkg::OP_READ) begin
                            fill_next     = fill_reg - n_take;
                            rd_index_next = rd_wrap[rfifo_pkg::ADDR_W-1:0];
                        end
                    end
                end
                rfifo_pkg::OP_REMOVE: begin
                    out_valid_next          = 1'b1;
                    out_next.transfer_count = n_take;
                    fill_next               = fill_reg - n_take;
                    rd_index_next           = rd_wrap[rfifo_pkg::ADDR_W-1:0];
                end
                rfifo_pkg::OP_CLEAR: begin
                    out_valid_next          = 1'b1;
                    out_next.transfer_count = fill_reg;
                    rd_index_next           = '0;
                    wr_index_next           = '0;
                    fill_next               = '0;
                    burst_next              = '0;
                end
                default: begin
                    out_valid_next          = 1'b1;
                    out_next.transfer_count = '0;
                end
            endcase
            out_next.occupancy  = fill_next;
            out_next.free_space = cap_eff - fill_next;
        end

        // pending element into the output register
        if (pend_move) begin
            out_valid_next          = 1'b1;
            out_next.read_data      = mem_rdata_reg;
            out_next.data_valid     = 1'b1;
            out_next.transfer_count = xfer_reg;
            out_next.occupancy      = fill_reg;
            out_next.free_space     = cap_eff - fill_reg;
            out_next.last           = pend_last_reg;
            pend_valid_next         = 1'b0;
        end

        // issue the next element read
        if (mem_re) begin
            pend_valid_next = 1'b1;
            pend_last_next  = (remain_reg == rfifo_pkg::CNT_W'(1));
            remain_next     = remain_reg - rfifo_pkg::CNT_W'(1);
            rd_ptr_next     = (ptr_inc >= cap_eff) ? '0
                              : ptr_inc[rfifo_pkg::ADDR_W-1:0];
        end

        // stream done once every element has left the pending stage
        if ((state_reg == ST_READ) && (remain_reg == '0) && (!pend_valid_reg || pend_move)) begin
            state_next = ST_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cap_reg        <= rfifo_pkg::CNT_W'(rfifo_pkg::DEPTH);
            rd_index_reg   <= '0;
            wr_index_reg   <= '0;
            fill_reg       <= '0;
            burst_reg      <= '0;
            remain_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            rd_index_reg   <= rd_index_next;
            wr_index_reg   <= wr_index_next;
            fill_reg       <= fill_next;
            burst_reg      <= burst_next;
            remain_reg     <= remain_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        rd_ptr_reg    <= rd_ptr_next;
        xfer_reg      <= xfer_next;
        pend_last_reg <= pend_last_next;
        out_reg       <= out_next;
    end

    // result ports
    assign m_valid          = out_valid_reg;
    assign m_read_data      = out_reg.read_data;
    assign m_data_valid     = out_reg.data_valid;
    assign m_transfer_count = out_reg.transfer_count;
    assign m_occupancy      = out_reg.occupancy;
    assign m_free_space     = out_reg.free_space;
    assign m_last           = out_reg.last;

endmodule
